// ===== hw/rtl/joystick_servo_rate_integrator_macros.svh =====
// Assertion macros shared by the joystick servo rate integrator RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef JOYSTICK_SERVO_RATE_INTEGRATOR_MACROS_SVH
`define JOYSTICK_SERVO_RATE_INTEGRATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JSRI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define JSRI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/jsri_pkg.sv =====
// Package for the joystick servo rate integrator: payload and control structs,
// register indexes and reset constants. No dependencies.
`default_nettype none

package jsri_pkg;

  localparam int PULSE_BITS = 12;
  localparam int AXIS_BITS  = 8;
  localparam int CFG_BITS   = 7;
  localparam int STEP_BITS  = 8;
  localparam int IDX_BITS   = 3;

  // Register indexes on the configuration port.
  localparam logic [IDX_BITS-1:0] CFG_DEADBAND    = 3'd0;
  localparam logic [IDX_BITS-1:0] CFG_MAX_STEP    = 3'd1;
  localparam logic [IDX_BITS-1:0] CFG_MIN_PULSE   = 3'd2;
  localparam logic [IDX_BITS-1:0] CFG_PAN_MAX     = 3'd3;
  localparam logic [IDX_BITS-1:0] CFG_TILT_MAX    = 3'd4;
  localparam logic [IDX_BITS-1:0] CFG_PAN_START   = 3'd5;
  localparam logic [IDX_BITS-1:0] CFG_TILT_START  = 3'd6;

  localparam logic [AXIS_BITS-1:0]  AXIS_CENTRE      = 8'd127;
  localparam logic [CFG_BITS-1:0]   DEADBAND_RESET   = 7'd6;
  localparam logic [CFG_BITS-1:0]   MAX_STEP_RESET   = 7'd30;
  localparam logic [PULSE_BITS-1:0] MIN_PULSE_RESET  = 12'd500;
  localparam logic [PULSE_BITS-1:0] PAN_MAX_RESET    = 12'd2300;
  localparam logic [PULSE_BITS-1:0] TILT_MAX_RESET   = 12'd1700;
  localparam logic [PULSE_BITS-1:0] PAN_START_RESET  = 12'd1500;
  localparam logic [PULSE_BITS-1:0] TILT_START_RESET = 12'd1500;

  typedef struct packed {
    logic                 pad_valid;
    logic [AXIS_BITS-1:0] axis_x;
    logic [AXIS_BITS-1:0] axis_y;
  } in_item_t;

  typedef struct packed {
    logic [PULSE_BITS-1:0] pan_pulse;
    logic [PULSE_BITS-1:0] tilt_pulse;
  } out_item_t;

  // Signed per-tick steps handed from front to back.
  typedef struct packed {
    logic signed [STEP_BITS-1:0] pan_step;
    logic signed [STEP_BITS-1:0] tilt_step;
  } step_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] deadband;
    logic [CFG_BITS-1:0] max_step;
  } front_cfg_t;

  typedef struct packed {
    logic [PULSE_BITS-1:0] min_pulse;
    logic [PULSE_BITS-1:0] pan_max;
    logic [PULSE_BITS-1:0] tilt_max;
  } back_cfg_t;

  // Position preset from a start register write.
  typedef struct packed {
    logic                  pan_load;
    logic                  tilt_load;
    logic [PULSE_BITS-1:0] value;
  } preset_t;

endpackage

`default_nettype wire

// ===== hw/rtl/jsri_front.sv =====
// Front end: accepts input items, scales both axes into signed steps and
// drops items that cause no result. Depends on jsri_pkg.
`default_nettype none

module jsri_front (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire jsri_pkg::in_item_t in_item,
  input  wire jsri_pkg::front_cfg_t cfg,
  input  wire logic               q_full,
  output logic                    push,
  output jsri_pkg::step_t         push_step
);

  // Deadband, then |d| * max_step / 128 truncated toward zero, sign restored.
  function automatic logic signed [jsri_pkg::STEP_BITS-1:0] axis_step(
    input logic [jsri_pkg::AXIS_BITS-1:0] axis,
    input logic [jsri_pkg::CFG_BITS-1:0]  db,
    input logic [jsri_pkg::CFG_BITS-1:0]  ms
  );
    logic signed [jsri_pkg::AXIS_BITS:0]     dev;
    logic [jsri_pkg::AXIS_BITS-1:0]          mag;
    logic [14:0]                             prod;
    logic [jsri_pkg::STEP_BITS-2:0]          smag;
    logic signed [jsri_pkg::STEP_BITS-1:0]   res;
    dev  = $signed({1'b0, axis}) - $signed({1'b0, jsri_pkg::AXIS_CENTRE});
    mag  = dev[jsri_pkg::AXIS_BITS] ? 8'(-dev) : dev[jsri_pkg::AXIS_BITS-1:0];
    prod = 15'(mag) * 15'(ms);
    smag = prod[13:7];
    if (mag < {1'b0, db}) begin
      res = '0;
    end else if (dev[jsri_pkg::AXIS_BITS]) begin
      res = 8'sd0 - $signed({1'b0, smag});
    end else begin
      res = $signed({1'b0, smag});
    end
    return res;
  endfunction

  logic signed [jsri_pkg::STEP_BITS-1:0] x_step;
  logic signed [jsri_pkg::STEP_BITS-1:0] y_step;

  always_comb begin
    x_step = axis_step(in_item.axis_x, cfg.deadband, cfg.max_step);
    y_step = axis_step(in_item.axis_y, cfg.deadband, cfg.max_step);
    push_step.pan_step  = 8'sd0 - x_step;
    push_step.tilt_step = y_step;
  end

  // Take an item whenever the queue has room; enqueue only live ones.
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready && in_item.pad_valid &&
                    ((x_step != '0) || (y_step != '0));

endmodule

`default_nettype wire

// ===== hw/rtl/jsri_queue.sv =====
// Short step queue between the front and back ends.
// Depends on jsri_pkg and the assertion macro header.
`default_nettype none
`include "joystick_servo_rate_integrator_macros.svh"

module jsri_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire jsri_pkg::step_t push_step,
  output logic                 full,
  input  wire logic            pop,
  output logic                 q_valid,
  output jsri_pkg::step_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  jsri_pkg::step_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_step;
    end
  end

  `JSRI_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "queue count over depth")
  `JSRI_ASSERT_NEXT(a_count_grow, do_push && !do_pop, count_r == $past(count_r) + 1'b1, "queue count did not grow")

endmodule

`default_nettype wire

// ===== hw/rtl/jsri_back.sv =====
// Back end: applies queued steps to the kept pulse widths, clamps them and
// holds the result in an output register. Depends on jsri_pkg and the macro header.
`default_nettype none
`include "joystick_servo_rate_integrator_macros.svh"

module jsri_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire jsri_pkg::back_cfg_t  cfg,
  input  wire jsri_pkg::preset_t    preset,
  input  wire logic                 q_valid,
  input  wire jsri_pkg::step_t      head,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output jsri_pkg::out_item_t       out_item
);

  localparam int PB = jsri_pkg::PULSE_BITS;
  localparam int VW = PB + 2;

  // Add step, raise to min, then lower to max (max wins when they cross).
  function automatic logic [PB-1:0] clamp_pulse(
    input logic [PB-1:0]                         pos,
    input logic signed [jsri_pkg::STEP_BITS-1:0] step,
    input logic [PB-1:0]                         lo,
    input logic [PB-1:0]                         hi
  );
    logic signed [VW-1:0] v;
    v = $signed({2'b00, pos}) + VW'(step);
    if (v < $signed({2'b00, lo})) begin
      v = $signed({2'b00, lo});
    end
    if (v > $signed({2'b00, hi})) begin
      v = $signed({2'b00, hi});
    end
    return v[PB-1:0];
  endfunction

  logic [PB-1:0]       pan_pos_r, tilt_pos_r;
  logic [PB-1:0]       pan_new, tilt_new;
  logic                out_valid_r, out_valid_nxt;
  jsri_pkg::out_item_t out_item_r;
  logic                no_preset;
  logic                result_is_pos;

  assign pan_new  = clamp_pulse(pan_pos_r, head.pan_step, cfg.min_pulse, cfg.pan_max);
  assign tilt_new = clamp_pulse(tilt_pos_r, head.tilt_step, cfg.min_pulse, cfg.tilt_max);

  // Advance when the output register is empty or being drained.
  assign pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_pos_r   <= jsri_pkg::PAN_START_RESET;
      tilt_pos_r  <= jsri_pkg::TILT_START_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (preset.pan_load) begin
        pan_pos_r <= preset.value;
      end else if (pop) begin
        pan_pos_r <= pan_new;
      end
      if (preset.tilt_load) begin
        tilt_pos_r <= preset.value;
      end else if (pop) begin
        tilt_pos_r <= tilt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item_r.pan_pulse  <= pan_new;
      out_item_r.tilt_pulse <= tilt_new;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign no_preset     = !preset.pan_load && !preset.tilt_load;
  assign result_is_pos = (out_item_r.pan_pulse == pan_pos_r) &&
                         (out_item_r.tilt_pulse == tilt_pos_r);

  `JSRI_ASSERT_NEXT(a_pop_shows, pop, out_valid_r, "popped item not presented")
  `JSRI_ASSERT_NOW(a_no_overwrite, out_valid_r && !out_ready, !pop, "pending result overwritten")
  `JSRI_ASSERT_NEXT(a_pos_matches, pop && no_preset, result_is_pos, "result off kept position")

endmodule

`default_nettype wire

// ===== hw/rtl/joystick_servo_rate_integrator.sv =====
// Top level of the joystick servo rate integrator: configuration registers,
// front end, step queue and back end. Depends on jsri_pkg, jsri_front,
// jsri_queue and jsri_back.
//
// Usage:
//   in_*  : one item per gamepad tick (pad_valid, axis_x, axis_y), valid/ready.
//   out_* : new pan and tilt pulse widths, valid/ready. An item gives a result
//           only when the pad is valid and an axis scales to a nonzero step
//           past the deadband; other items are taken and dropped silently.
//   cfg_* : register writes (index, data), always ready. Writing a start
//           register also presets that channel's position. Write only while
//           no item is in flight.
// Path: a live item goes into the step queue, then into the output register.
// Throughput: one item per cycle while the queue has room. The front end
//   scales both axes in the accept cycle; the back end applies one queued
//   step per cycle while its output register is empty or being drained,
//   limited by its single add-and-clamp update of the kept positions.
// Stalls: when out_ready is low the result holds in the output register and
//   live items pile up in the QUEUE_DEPTH entry step queue; in_ready drops
//   only when that queue is full.
// Reset (rst_n low, synchronous): registers take their defaults, positions
//   load 1500 and 1500, the queue empties and out_valid clears.
`default_nettype none

module joystick_servo_rate_integrator #(
  parameter int QUEUE_DEPTH = 4  // step queue entries, 2 to 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire jsri_pkg::in_item_t                in_item,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output jsri_pkg::out_item_t                    out_item,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [jsri_pkg::IDX_BITS-1:0]     cfg_index,
  input  wire logic [jsri_pkg::PULSE_BITS-1:0]   cfg_data
);

  logic [jsri_pkg::CFG_BITS-1:0]   deadband_r, max_step_r;
  logic [jsri_pkg::PULSE_BITS-1:0] min_pulse_r, pan_max_r, tilt_max_r;
  logic                            cfg_fire;

  jsri_pkg::front_cfg_t front_cfg;
  jsri_pkg::back_cfg_t  back_cfg;
  jsri_pkg::preset_t    preset;
  jsri_pkg::step_t      push_step, head;
  logic                 push, q_full, q_valid, pop;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r   <= jsri_pkg::DEADBAND_RESET;
      max_step_r   <= jsri_pkg::MAX_STEP_RESET;
      min_pulse_r  <= jsri_pkg::MIN_PULSE_RESET;
      pan_max_r    <= jsri_pkg::PAN_MAX_RESET;
      tilt_max_r   <= jsri_pkg::TILT_MAX_RESET;
    end else if (cfg_fire) begin
      case (cfg_index)
        jsri_pkg::CFG_DEADBAND:   deadband_r   <= cfg_data[jsri_pkg::CFG_BITS-1:0];
        jsri_pkg::CFG_MAX_STEP:   max_step_r   <= cfg_data[jsri_pkg::CFG_BITS-1:0];
        jsri_pkg::CFG_MIN_PULSE:  min_pulse_r  <= cfg_data;
        jsri_pkg::CFG_PAN_MAX:    pan_max_r    <= cfg_data;
        jsri_pkg::CFG_TILT_MAX:   tilt_max_r   <= cfg_data;
        jsri_pkg::CFG_PAN_START,
        jsri_pkg::CFG_TILT_START: begin
          // start values act only through the position preset below
        end
        default: begin
        end
      endcase
    end
  end

  // A start write presets that channel's position straight from the write data.
  assign front_cfg.deadband = deadband_r;
  assign front_cfg.max_step = max_step_r;
  assign back_cfg.min_pulse = min_pulse_r;
  assign back_cfg.pan_max   = pan_max_r;
  assign back_cfg.tilt_max  = tilt_max_r;
  assign preset.pan_load    = cfg_fire && (cfg_index == jsri_pkg::CFG_PAN_START);
  assign preset.tilt_load   = cfg_fire && (cfg_index == jsri_pkg::CFG_TILT_START);
  assign preset.value       = cfg_data;

  jsri_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cfg       (front_cfg),
    .q_full    (q_full),
    .push      (push),
    .push_step (push_step)
  );

  jsri_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_step (push_step),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  jsri_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (back_cfg),
    .preset    (preset),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
